>>> rtl/dfaa_pkg.sv
`timescale 1ns / 1ps

package dfaa_pkg;

	localparam int NUM_STATES  = 32;
	localparam int NUM_SYMBOLS = 32;

	// fixed field widths
	localparam int REQ_W  = 3;
	localparam int ST_W   = 5;
	localparam int COL_W  = 5;
	localparam int CHAR_W = 8;

	// derived sizes
	localparam int ST_AW    = $clog2(NUM_STATES);
	localparam int SYM_AW   = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
	localparam int TT_DEPTH = NUM_STATES * NUM_SYMBOLS;
	localparam int TT_AW    = $clog2(TT_DEPTH);
	localparam int TT_DW    = ST_W + 1;

	typedef enum logic [REQ_W-1:0] {
		REQ_LOAD_TRANS = 3'd0,
		REQ_LOAD_FLAG  = 3'd1,
		REQ_LOAD_ALPHA = 3'd2,
		REQ_SYMBOL     = 3'd3,
		REQ_END        = 3'd4
	} req_code_t;

	typedef struct packed {
		logic              en;
		logic [SYM_AW-1:0] col;
		logic [CHAR_W-1:0] code;
	} alpha_wr_t;

	typedef struct packed {
		logic              found;
		logic [SYM_AW-1:0] col;
	} alpha_hit_t;

endpackage

>>> rtl/dfaa_alpha.sv
`timescale 1ns / 1ps

module dfaa_alpha (
	input  logic                        clk,
	input  logic                        arst_n,
	input  dfaa_pkg::alpha_wr_t         wr,
	input  logic [dfaa_pkg::CHAR_W-1:0] char_code,
	output dfaa_pkg::alpha_hit_t        hit
);

	logic [dfaa_pkg::NUM_SYMBOLS-1:0] valid_q;
	logic [dfaa_pkg::CHAR_W-1:0]      code_q [dfaa_pkg::NUM_SYMBOLS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.en) begin
			valid_q[wr.col] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			code_q[wr.col] <= wr.code;
		end
	end

	// lowest matching column wins
	always_comb begin
		hit.found = 1'b0;
		hit.col   = '0;
		for (int i = dfaa_pkg::NUM_SYMBOLS - 1; i >= 0; i--) begin
			if (valid_q[i] && (code_q[i] == char_code)) begin
				hit.found = 1'b1;
				hit.col   = dfaa_pkg::SYM_AW'(i);
			end
		end
	end

endmodule

>>> rtl/table_driven_dfa_acceptor.sv
`timescale 1ns / 1ps

// Programmable DFA acceptor. One request beat is taken per clock: transition
// loads, accepting-flag loads, alphabet loads, symbols and end-of-word markers
// all flow through a two-stage path; after the reset sweep, only an end-of-word
// beat whose result cannot leave (response register full, not taken) holds the request side.
// A symbol is matched against the alphabet on acceptance, reads the
// transition memory in stage one, and its target is forwarded from the
// memory's registered output straight into the next symbol's read address,
// so back-to-back symbols run at one per cycle. Each end-of-word beat gives
// one response beat (accepted, died) and restarts the word at state 0.
// After reset the transition memory is swept invalid, one entry per cycle,
// over all NUM_STATES * NUM_SYMBOLS entries (1024 at the default size); request
// ready stays low during that sweep.

module table_driven_dfa_acceptor (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  logic [dfaa_pkg::REQ_W-1:0]  req_type,
	input  logic [dfaa_pkg::ST_W-1:0]   state_index,
	input  logic [dfaa_pkg::COL_W-1:0]  column,
	input  logic [dfaa_pkg::ST_W-1:0]   target_state,
	input  logic                        accept_flag,
	input  logic [dfaa_pkg::CHAR_W-1:0] char_code,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output logic                        accepted,
	output logic                        died
);

	// request acceptance
	logic                req_fire;
	dfaa_pkg::req_code_t req_code;
	logic                trans_ok;
	logic                st_ok;
	logic                col_ok;

	// alphabet store
	dfaa_pkg::alpha_wr_t  alpha_wr;
	dfaa_pkg::alpha_hit_t alpha_hit;

	// accepting flags, one per state
	logic [dfaa_pkg::NUM_STATES-1:0] acc_flags_q;

	// stage one: memory access and word bookkeeping
	logic                        vld_s1;
	dfaa_pkg::req_code_t         kind_s1;
	logic                        trans_ok_s1;
	logic [dfaa_pkg::TT_AW-1:0]  waddr_s1;
	logic [dfaa_pkg::ST_W-1:0]   tgt_s1;
	logic                        found_s1;
	logic [dfaa_pkg::SYM_AW-1:0] col_s1;
	logic                        s1_go;

	// stage two: transition read data arrives
	logic                       rd_s2;
	logic [dfaa_pkg::TT_DW-1:0] rdata_s2;

	// word state
	logic [dfaa_pkg::ST_W-1:0] state_q;
	logic                      dead_q;
	logic [dfaa_pkg::ST_W-1:0] state_eff;
	logic                      dead_eff;
	logic                      sym_read;
	logic                      sym_die;
	logic                      is_end;

	// transition memory: {valid, target}
	logic [dfaa_pkg::TT_DW-1:0] tt_mem [dfaa_pkg::TT_DEPTH];
	logic                       tt_we;
	logic [dfaa_pkg::TT_AW-1:0] tt_waddr;
	logic [dfaa_pkg::TT_DW-1:0] tt_wdata;
	logic [dfaa_pkg::TT_AW-1:0] tt_raddr;

	// reset sweep
	logic                       clr_busy_q;
	logic [dfaa_pkg::TT_AW-1:0] clr_cnt_q;

	// response register
	logic rsp_valid_q;
	logic accepted_q;
	logic died_q;

	assign req_code = dfaa_pkg::req_code_t'(req_type);
	assign is_end   = vld_s1 && (kind_s1 == dfaa_pkg::REQ_END);
	// only an end beat that finds the response register blocked stalls
	assign s1_go     = !(is_end && rsp_valid_q && !rsp_ready);
	assign req_ready = !clr_busy_q && (!vld_s1 || s1_go);
	assign req_fire  = req_valid && req_ready;

	assign st_ok    = int'(state_index) < dfaa_pkg::NUM_STATES;
	assign col_ok   = int'(column) < dfaa_pkg::NUM_SYMBOLS;
	assign trans_ok = st_ok && col_ok && (int'(target_state) < dfaa_pkg::NUM_STATES);

	// alphabet loads land at acceptance so the very next symbol sees them
	assign alpha_wr.en   = req_fire && (req_code == dfaa_pkg::REQ_LOAD_ALPHA) && col_ok;
	assign alpha_wr.col  = dfaa_pkg::SYM_AW'(column);
	assign alpha_wr.code = char_code;

	dfaa_alpha u_alpha (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (alpha_wr),
		.char_code (char_code),
		.hit       (alpha_hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_flags_q <= '0;
		end else if (req_fire && (req_code == dfaa_pkg::REQ_LOAD_FLAG) && st_ok) begin
			acc_flags_q[dfaa_pkg::ST_AW'(state_index)] <= accept_flag;
		end
	end

	// stage one capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (req_ready) begin
			vld_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			kind_s1     <= req_code;
			trans_ok_s1 <= trans_ok;
			waddr_s1    <= dfaa_pkg::TT_AW'(int'(state_index) * dfaa_pkg::NUM_SYMBOLS
				+ int'(column));
			tgt_s1      <= target_state;
			found_s1    <= alpha_hit.found;
			col_s1      <= alpha_hit.col;
		end
	end

	// forward the symbol whose transition read completes this cycle
	always_comb begin
		state_eff = state_q;
		dead_eff  = dead_q;
		if (rd_s2) begin
			if (rdata_s2[dfaa_pkg::TT_DW-1]) begin
				state_eff = rdata_s2[dfaa_pkg::ST_W-1:0];
			end else begin
				dead_eff = 1'b1;
			end
		end
	end

	// a dead word ignores symbols; an unknown byte kills it
	assign sym_read = vld_s1 && (kind_s1 == dfaa_pkg::REQ_SYMBOL) && !dead_eff && found_s1;
	assign sym_die  = vld_s1 && (kind_s1 == dfaa_pkg::REQ_SYMBOL) && !dead_eff && !found_s1;
	assign tt_raddr = dfaa_pkg::TT_AW'(int'(state_eff) * dfaa_pkg::NUM_SYMBOLS + int'(col_s1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			dead_q  <= 1'b0;
			rd_s2   <= 1'b0;
		end else begin
			rd_s2 <= sym_read;
			if (is_end && s1_go) begin
				// restart for the next word
				state_q <= '0;
				dead_q  <= 1'b0;
			end else begin
				state_q <= state_eff;
				dead_q  <= dead_eff || sym_die;
			end
		end
	end

	// reset sweep marks every transition invalid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clr_busy_q) begin
			if (clr_cnt_q == dfaa_pkg::TT_AW'(dfaa_pkg::TT_DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end else begin
				clr_cnt_q <= clr_cnt_q + dfaa_pkg::TT_AW'(1);
			end
		end
	end

	assign tt_we    = clr_busy_q
		|| (vld_s1 && (kind_s1 == dfaa_pkg::REQ_LOAD_TRANS) && trans_ok_s1);
	assign tt_waddr = clr_busy_q ? clr_cnt_q : waddr_s1;
	assign tt_wdata = clr_busy_q ? '0 : {1'b1, tgt_s1};

	always_ff @(posedge clk) begin
		if (tt_we) begin
			tt_mem[tt_waddr] <= tt_wdata;
		end
		if (sym_read) begin
			rdata_s2 <= tt_mem[tt_raddr];
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (is_end && s1_go) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (is_end && s1_go) begin
			accepted_q <= !dead_eff && acc_flags_q[dfaa_pkg::ST_AW'(state_eff)];
			died_q     <= dead_eff;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign accepted  = accepted_q;
	assign died      = died_q;

endmodule
